### rtl/a64d_pkg.sv
// Package for the AArch64 subset decoder: class table, field codes, result struct.
// No dependencies.
package a64d_pkg;
    localparam int NumClasses = 46;
    localparam int MAX_BYTES = 1048576;
    localparam logic [5:0] KIND_UNKNOWN = 6'd46;
    localparam logic [17:0] TALLY_MAX = 18'h3ffff;

    localparam logic [1:0] VAR_PLAIN = 2'd0;
    localparam logic [1:0] VAR_WEXT = 2'd1;
    localparam logic [1:0] VAR_SHR = 2'd2;
    localparam logic [1:0] VAR_WB = 2'd3;

    localparam logic [31:0] CLASS_MASK [NumClasses] = '{
        32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hfc000000, 32'hff000000,
        32'hffc003e0, 32'hffc003e0, 32'hfff00000, 32'hfff00000, 32'hff800000,
        32'hff800000, 32'hffc0001f, 32'hffc0001f, 32'hffc0001f, 32'hffc0001f,
        32'hff000000, 32'hff400000, 32'hff400000, 32'hff000000, 32'hff000000,
        32'hff000000, 32'hff400000, 32'hff400000, 32'hff000000, 32'hff000000,
        32'hff000000, 32'hff800000, 32'hff000000, 32'hff000000, 32'hff000000,
        32'hff800000, 32'hff000000, 32'hffc02000, 32'hffc00000, 32'hff800000,
        32'hff800000, 32'hff400400, 32'hff400400, 32'hff400000, 32'hff400000,
        32'hff400000, 32'hff400000, 32'hff400000, 32'hff400000, 32'hff400000,
        32'hff400000
    };

    localparam logic [31:0] CLASS_PATTERN [NumClasses] = '{
        32'hd503201f, 32'hd65f03c0, 32'h14000000, 32'h94000000, 32'h54000000,
        32'haa0003e0, 32'h2a0003e0, 32'hd2800000, 32'h52800000, 32'hf2800000,
        32'h72800000, 32'heb00001f, 32'h6b00001f, 32'hf100001f, 32'h7100001f,
        32'h8b000000, 32'h91000000, 32'h91400000, 32'h11000000, 32'hcb000000,
        32'h4b000000, 32'hd1000000, 32'hd1400000, 32'h51000000, 32'h8a000000,
        32'h0a000000, 32'h92000000, 32'h12000000, 32'haa000000, 32'h2a000000,
        32'hb2000000, 32'h32000000, 32'h9ac02000, 32'hd3400000, 32'h58000000,
        32'h18000000, 32'hb8000400, 32'hb8400400, 32'hb9000000, 32'hb9400000,
        32'hf8000000, 32'hf8400000, 32'hf9000000, 32'hf9400000, 32'ha9000000,
        32'ha9400000
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [4:0]  dest_reg;
        logic [4:0]  first_src;
        logic [4:0]  second_src;
        logic [63:0] imm_value;
        logic [5:0]  shift_amount;
        logic [5:0]  bit_high;
        logic [14:0] mem_offset;
        logic [28:0] target_address;
        logic [4:0]  condition;
        logic [1:0]  variant;
    } t_dec;
endpackage

### rtl/arm64_subset_instruction_decoder.sv
// Channel  | Dir | tdata fields (low bit up)
// s_axis   | in  | instruction_word[31:0], byte_offset[51:32], pad to 56
// m_axis   | out | kind, dest_reg, first_src, second_src, imm_value, shift_amount,
//          |     | bit_high, mem_offset, target_address, condition, variant,
//          |     | unknown_tally; pad to 168
// One beat per cycle unless m_axis stalls or the tally is clearing; a taken beat
// loads stage one with the memory read, then moves on into the output register.
// Tally memory is read the cycle an unknown beat is taken and written back when it
// leaves stage one, with forwarding of the last written entry.
// After reset a pass clears all 256 entries; s_axis_tready stays low meanwhile.
// Stalls on m_axis hold the stage-one beat; a two-entry stage pair keeps full rate.
module arm64_subset_instruction_decoder
    import a64d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // instruction_word, byte_offset
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // kind .. unknown_tally (see table)
);
    localparam int AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    logic [31:0]      word;
    logic [19:0]      off;
    logic [AddrW-1:0] pc;
    t_dec             dec;
    logic             busy;
    logic [17:0]      tally;
    logic             acc;
    logic             adv;
    logic             r_s1_vld;
    t_dec             r_s1;
    logic             r_out_vld;
    t_dec             r_out;
    logic [17:0]      r_out_tally;

    assign word = s_axis_tdata[31:0];
    assign off = s_axis_tdata[51:32];
    assign pc = AddrW'(off);

    a64d_field_dec #(.AddrW(AddrW)) u_dec (
        .i_word(word),
        .i_pc(pc),
        .o_dec(dec)
    );

    assign adv = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !busy && (!r_s1_vld || adv);
    assign acc = s_axis_tvalid && s_axis_tready;

    a64d_tally u_tally (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(acc && dec.kind == KIND_UNKNOWN),
        .i_rd_idx(word[31:24]),
        .i_upd(adv && r_s1.kind == KIND_UNKNOWN),
        .o_tally(tally),
        .o_busy(busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (acc) begin
            r_s1 <= dec;
        end
        if (adv) begin
            r_out <= r_s1;
            r_out_tally <= (r_s1.kind == KIND_UNKNOWN) ? tally : 18'd0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata = {2'd0, r_out_tally, r_out.variant, r_out.condition,
        r_out.target_address, r_out.mem_offset, r_out.bit_high, r_out.shift_amount,
        r_out.imm_value, r_out.second_src, r_out.first_src, r_out.dest_reg, r_out.kind};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output beat dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("advance lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5:0] != KIND_UNKNOWN) |-> m_axis_tdata[165:148] == 18'd0)
        else $error("tally on known kind");
endmodule

### rtl/a64d_field_dec.sv
// Combinational class match and field extraction for one instruction word.
// Depends on a64d_pkg.
module a64d_field_dec
    import a64d_pkg::*;
#(
    parameter int AddrW = 20
) (
    input  logic [31:0]      i_word,
    input  logic [AddrW-1:0] i_pc,
    output t_dec             o_dec
);
    logic [5:0]  kind;
    logic [63:0] m64;
    logic [63:0] m64d;
    logic [31:0] m32;
    logic [63:0] m32d;
    logic [5:0]  r64;
    logic [4:0]  r32;
    logic [28:0] pc29;
    logic [28:0] br26;
    logic [28:0] br19;

    always_comb begin
        kind = KIND_UNKNOWN;
        for (int i = NumClasses - 1; i >= 0; i--) begin
            if ((i_word & CLASS_MASK[i]) == CLASS_PATTERN[i]) begin
                kind = 6'(i);
            end
        end
    end

    always_comb begin
        m64 = '0;
        for (int i = 0; i < 64; i++) begin
            m64[i] = (7'(i) <= {1'b0, i_word[15:10]});
        end
        r64 = i_word[21:16];
        m64d = (m64 >> r64) | (m64 << (7'd64 - {1'b0, r64}));
        m32 = '0;
        for (int i = 0; i < 32; i++) begin
            m32[i] = (6'(i) <= {1'b0, i_word[14:10]});
        end
        r32 = i_word[20:16];
        m32d = {32'd0, (m32 >> r32) | (m32 << (6'd32 - {1'b0, r32}))};
    end

    assign pc29 = 29'(i_pc);
    assign br26 = pc29 + {{1{i_word[25]}}, i_word[25:0], 2'b00};
    assign br19 = pc29 + {{8{i_word[23]}}, i_word[23:5], 2'b00};

    always_comb begin
        o_dec = '0;
        o_dec.kind = kind;
        if (kind >= 6'd5 && kind != KIND_UNKNOWN) begin
            o_dec.dest_reg = i_word[4:0];
            o_dec.first_src = i_word[9:5];
        end
        case (kind)
            6'd2, 6'd3: o_dec.target_address = br26;
            6'd4: begin
                o_dec.target_address = br19;
                o_dec.condition = i_word[4:0];
            end
            6'd5, 6'd6, 6'd12, 6'd19, 6'd20, 6'd24, 6'd25:
                o_dec.second_src = i_word[20:16];
            6'd7, 6'd8: o_dec.imm_value = {48'd0, i_word[20:5]};
            6'd9, 6'd10: begin
                o_dec.imm_value = {48'd0, i_word[20:5]};
                o_dec.shift_amount = {i_word[22:21], 4'd0};
            end
            6'd11: begin
                o_dec.second_src = i_word[20:16];
                o_dec.variant = i_word[21] ? VAR_WEXT : VAR_PLAIN;
            end
            6'd13, 6'd14, 6'd16, 6'd17, 6'd18, 6'd21, 6'd22, 6'd23:
                o_dec.imm_value = {52'd0, i_word[21:10]};
            6'd15: begin
                o_dec.second_src = i_word[20:16];
                if (i_word[21]) begin
                    o_dec.variant = VAR_WEXT;
                end else begin
                    o_dec.shift_amount = i_word[15:10];
                    o_dec.variant = i_word[22] ? VAR_SHR : VAR_PLAIN;
                end
            end
            6'd26, 6'd30: o_dec.imm_value = m64d;
            6'd27, 6'd31: o_dec.imm_value = m32d;
            6'd28: begin
                o_dec.second_src = i_word[20:16];
                o_dec.shift_amount = i_word[15:10];
            end
            6'd29: begin
                o_dec.second_src = i_word[20:16];
                o_dec.shift_amount = {1'b0, i_word[14:10]};
            end
            6'd32: begin
                o_dec.second_src = i_word[20:16];
                o_dec.variant = i_word[10] ? VAR_SHR : VAR_PLAIN;
            end
            6'd33: begin
                o_dec.shift_amount = i_word[21:16];
                o_dec.bit_high = i_word[15:10];
            end
            6'd34, 6'd35: begin
                o_dec.first_src = '0;
                o_dec.target_address = {9'd0, i_word[22:5], 2'b00};
            end
            6'd36, 6'd37: o_dec.mem_offset = {{6{i_word[20]}}, i_word[20:12]};
            6'd38, 6'd39: o_dec.mem_offset = {1'b0, i_word[21:10], 2'b00};
            6'd40, 6'd41: o_dec.mem_offset = {{6{i_word[20]}}, i_word[20:15], 3'b000};
            6'd42, 6'd43: o_dec.mem_offset = {6'd0, i_word[15:10], 3'b000};
            6'd44, 6'd45: begin
                o_dec.second_src = i_word[14:10];
                o_dec.mem_offset = {{5{i_word[21]}}, i_word[21:15], 3'b000};
                o_dec.variant = i_word[23] ? VAR_WB : VAR_PLAIN;
            end
            default: ;
        endcase
    end
endmodule

### rtl/a64d_tally.sv
// Unknown-word tally: 256x18 memory, read-modify-write with forwarding.
// Clearing pass after reset. Depends on a64d_pkg.
module a64d_tally
    import a64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [7:0]  i_rd_idx,
    input  logic        i_upd,
    output logic [17:0] o_tally,
    output logic        o_busy
);
    logic [17:0] r_mem [256];
    logic [17:0] r_rd_data;
    logic [7:0]  r_idx;
    logic        r_upd;
    logic [17:0] r_fwd;
    logic [7:0]  r_fwd_idx;
    logic        r_fwd_vld;
    logic [8:0]  r_clr;
    logic [17:0] cur;
    logic [17:0] n_val;

    assign o_busy = !r_clr[8];
    assign cur = (r_fwd_vld && r_fwd_idx == r_idx) ? r_fwd : r_rd_data;
    assign n_val = (cur == TALLY_MAX) ? cur : cur + 18'd1;
    assign o_tally = n_val;

    always_ff @(posedge i_clk) begin
        if (!r_clr[8]) begin
            r_mem[r_clr[7:0]] <= '0;
        end else if (r_upd && i_upd) begin
            r_mem[r_idx] <= n_val;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_upd <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (!r_clr[8]) begin
                r_clr <= r_clr + 9'd1;
            end
            if (r_upd && i_upd) begin
                r_fwd <= n_val;
                r_fwd_idx <= r_idx;
                r_fwd_vld <= 1'b1;
            end
            if (i_rd_en) begin
                r_upd <= 1'b1;
                r_idx <= i_rd_idx;
            end else if (i_upd) begin
                r_upd <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upd && i_upd) |=> r_fwd_vld)
        else $error("forward not loaded");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !i_rd_en)
        else $error("read during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd |-> (o_tally != 18'd0))
        else $error("tally zero after update");
endmodule

### tb/sv/testbench.sv
// Testbench for arm64_subset_instruction_decoder: random and directed words, scoreboard.
// Depends on a64d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
    import a64d_pkg::*;

    localparam int ItemCount = 800;
    localparam int CycleLimit = 200000;
    localparam int OffsetBytes = 1048576;

    typedef struct packed {
        logic [17:0] unknown_tally;
        logic [1:0]  variant;
        logic [4:0]  condition;
        logic [28:0] target_address;
        logic [14:0] mem_offset;
        logic [5:0]  bit_high;
        logic [5:0]  shift_amount;
        logic [63:0] imm_value;
        logic [4:0]  second_src;
        logic [4:0]  first_src;
        logic [4:0]  dest_reg;
        logic [5:0]  kind;
    } t_decoded;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;   // instruction_word, byte_offset
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;   // kind .. unknown_tally, pad

    logic [55:0]  pending_words [$];
    t_decoded     expected_decodes [$];
    logic [17:0]  unknown_tallies [256];
    int           mismatch_count;
    int           cycle_count;
    int           idle_free;
    bit           feeding_done;
    bit           in_taken;

    arm64_subset_instruction_decoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] ones_upto(int count);
        if (count >= 64) return '1;
        return (64'd1 << count) - 64'd1;
    endfunction

    function automatic logic [63:0] rotated_mask64(logic [31:0] w);
        logic [63:0] m;
        int r;
        m = ones_upto(int'(w[15:10]) + 1);
        r = int'(w[21:16]);
        if (r == 0) return m;
        return (m >> r) | (m << (64 - r));
    endfunction

    function automatic logic [63:0] rotated_mask32(logic [31:0] w);
        logic [31:0] m;
        int r;
        m = 32'(ones_upto(int'(w[14:10]) + 1));
        r = int'(w[20:16]);
        if (r != 0) m = (m >> r) | (m << (32 - r));
        return {32'd0, m};
    endfunction

    function automatic t_decoded decode_word(logic [31:0] w, logic [19:0] offset);
        t_decoded res;
        logic [63:0] pc;
        int k;
        res = '0;
        pc = 64'(offset) % OffsetBytes;
        k = int'(KIND_UNKNOWN);
        for (int i = 0; i < NumClasses; i++) begin
            if ((w & CLASS_MASK[i]) == CLASS_PATTERN[i]) begin
                k = i;
                break;
            end
        end
        res.kind = 6'(k);
        if (k >= 5 && k != int'(KIND_UNKNOWN)) begin
            res.dest_reg = w[4:0];
            res.first_src = w[9:5];
        end
        case (k)
            2, 3: res.target_address = 29'(pc + 64'({{38{w[25]}}, w[25:0]} << 2));
            4: begin
                res.target_address = 29'(pc + 64'({{45{w[23]}}, w[23:5]} << 2));
                res.condition = w[4:0];
            end
            5, 6, 12, 19, 20, 24, 25: res.second_src = w[20:16];
            7, 8: res.imm_value = 64'(w[20:5]);
            9, 10: begin
                res.imm_value = 64'(w[20:5]);
                res.shift_amount = 6'(w[22:21] * 16);
            end
            11: begin
                res.second_src = w[20:16];
                res.variant = w[21] ? VAR_WEXT : VAR_PLAIN;
            end
            13, 14, 16, 17, 18, 21, 22, 23: res.imm_value = 64'(w[21:10]);
            15: begin
                res.second_src = w[20:16];
                if (w[21]) begin
                    res.variant = VAR_WEXT;
                end else begin
                    res.shift_amount = w[15:10];
                    res.variant = w[22] ? VAR_SHR : VAR_PLAIN;
                end
            end
            26, 30: res.imm_value = rotated_mask64(w);
            27, 31: res.imm_value = rotated_mask32(w);
            28: begin
                res.second_src = w[20:16];
                res.shift_amount = w[15:10];
            end
            29: begin
                res.second_src = w[20:16];
                res.shift_amount = 6'(w[14:10]);
            end
            32: begin
                res.second_src = w[20:16];
                res.variant = w[10] ? VAR_SHR : VAR_PLAIN;
            end
            33: begin
                res.shift_amount = w[21:16];
                res.bit_high = w[15:10];
            end
            34, 35: begin
                res.first_src = '0;
                res.target_address = 29'({w[22:5], 2'b00});
            end
            36, 37: res.mem_offset = 15'({{6{w[20]}}, w[20:12]});
            38, 39: res.mem_offset = 15'({w[21:10], 2'b00});
            40, 41: res.mem_offset = 15'({{9{w[20]}}, w[20:15]} * 8);
            42, 43: res.mem_offset = 15'(w[15:10] * 8);
            44, 45: begin
                res.second_src = w[14:10];
                res.mem_offset = 15'({{8{w[21]}}, w[21:15]} * 8);
                res.variant = w[23] ? VAR_WB : VAR_PLAIN;
            end
            int'(KIND_UNKNOWN): begin
                if (unknown_tallies[w[31:24]] < TALLY_MAX)
                    unknown_tallies[w[31:24]] += 18'd1;
                res.unknown_tally = unknown_tallies[w[31:24]];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_decode(t_decoded got, t_decoded want);
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.dest_reg !== want.dest_reg)
            report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
        if (got.first_src !== want.first_src)
            report_mismatch("first_src", got.first_src, want.first_src);
        if (got.second_src !== want.second_src)
            report_mismatch("second_src", got.second_src, want.second_src);
        if (got.imm_value !== want.imm_value)
            report_mismatch("imm_value", got.imm_value, want.imm_value);
        if (got.shift_amount !== want.shift_amount)
            report_mismatch("shift_amount", got.shift_amount, want.shift_amount);
        if (got.bit_high !== want.bit_high)
            report_mismatch("bit_high", got.bit_high, want.bit_high);
        if (got.mem_offset !== want.mem_offset)
            report_mismatch("mem_offset", got.mem_offset, want.mem_offset);
        if (got.target_address !== want.target_address)
            report_mismatch("target_address", got.target_address, want.target_address);
        if (got.condition !== want.condition)
            report_mismatch("condition", got.condition, want.condition);
        if (got.variant !== want.variant)
            report_mismatch("variant", got.variant, want.variant);
        if (got.unknown_tally !== want.unknown_tally)
            report_mismatch("unknown_tally", got.unknown_tally, want.unknown_tally);
    endtask

    function automatic logic [31:0] class_word(int k);
        logic [31:0] w;
        w = $urandom();
        return (w & ~CLASS_MASK[k]) | CLASS_PATTERN[k];
    endfunction

    task automatic queue_word(logic [31:0] w, logic [19:0] offset);
        pending_words.push_back({4'd0, offset, w});
    endtask

    initial begin
        logic [31:0] w;
        logic [19:0] offset;
        for (int i = 0; i < 256; i++) unknown_tallies[i] = '0;
        mismatch_count = 0;
        feeding_done = 1'b0;
        queue_word(32'h0000_0000, 20'h00000);
        queue_word(32'hffff_ffff, 20'hfffff);
        queue_word(32'h17ff_ffff, 20'h00000);
        queue_word(32'h9400_0000, 20'hffffc);
        queue_word(32'h54ff_ffe0, 20'h00001);
        queue_word(32'h92ff_ffff, 20'h00000);
        queue_word(32'h923f_fc00, 20'h00000);
        queue_word(32'h123f_fc00, 20'h00000);
        queue_word(32'hb27f_7fff, 20'h00000);
        queue_word(32'h8b20_0000, 20'h00000);
        queue_word(32'h8b40_fc00, 20'h00000);
        queue_word(32'hb850_0400, 20'h00000);
        queue_word(32'ha9c0_0000, 20'h00000);
        for (int k = 0; k < NumClasses; k++) queue_word(class_word(k), 20'($urandom()));
        for (int i = 0; i < ItemCount; i++) begin
            offset = 20'($urandom());
            if ($urandom_range(0, 9) < 7) begin
                w = class_word($urandom_range(0, NumClasses - 1));
            end else begin
                w = $urandom();
                // concentrate unknown words on few top bytes so tallies climb
                if ($urandom_range(0, 1) == 0) w[31:24] = 8'($urandom_range(0, 3));
            end
            queue_word(w, offset);
        end
        feeding_done = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && !in_taken) begin
                // hold the waiting beat
            end else if (pending_words.size() != 0 &&
                (idle_free > 0 || $urandom_range(0, 99) >= 18)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_words[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= (idle_free > 0 || $urandom_range(0, 99) >= 18);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_decodes.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
            end else begin
                compare_decode(t_decoded'(m_axis_tdata[165:0]), expected_decodes.pop_front());
            end
        end
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            expected_decodes.push_back(decode_word(s_axis_tdata[31:0],
                                                   s_axis_tdata[51:32]));
            void'(pending_words.pop_front());
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cycle_count = 0;
        idle_free = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(feeding_done && pending_words.size() == 0 && !s_axis_tvalid &&
                 expected_decodes.size() == 0) && cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count % 4000 == 1000) idle_free = 600;
            else if (idle_free > 0) idle_free--;
        end
        if (cycle_count >= CycleLimit) begin
            $display("arm64_subset_instruction_decoder verification failed");
            $finish;
        end else begin
            repeat (10) @(posedge i_clk);
            if (mismatch_count == 0 && expected_decodes.size() == 0) begin
                $display("arm64_subset_instruction_decoder verification clean");
            end else begin
                $display("arm64_subset_instruction_decoder verification failed");
            end
            $finish;
        end
    end
endmodule
